// ===== rtl/core/sgss_pkg.sv =====
// Shared constants and types for the subsampled grid SAD search block.
package sgss_pkg;

    // Command codes carried by the input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRCH_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRCH_DEPTH = 3'd4;

    // Field widths.
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned OFS_W    = 6;
    localparam int unsigned SAD_W    = 12;
    localparam int unsigned ROWSAD_W = 10;
    localparam int unsigned THR_W    = 17;
    localparam int unsigned ROW_W    = 5;
    localparam int unsigned CNT_W    = 7;

    // Loads address at most 32 rows and four groups of eight columns.
    localparam int unsigned LOAD_ROWS = 32;
    localparam int unsigned BLOCK_W   = 4;

    localparam logic [THR_W-1:0] THRESH_START = 17'd100000;
    localparam logic [CNT_W-1:0] MAX_RESULTS  = 7'd64;

    // Bookkeeping that travels with a row read into the accumulate stage.
    typedef struct packed {
        logic [OFS_W-1:0] x;
        logic [OFS_W-1:0] y;
        logic [3:0]       c0;
        logic             row_ok;
        logic [1:0]       ref_row;
        logic             last_row;
        logic             last_pos;
    } t_rd_meta;

endpackage

// ===== rtl/core/subsampled_grid_sad_search_top.sv =====
// Top level of the subsampled grid SAD search: area store, grid walker and candidate output.
// Loads: a load is written at its accepting edge; loads take one word per cycle while o_stall is low.
// Runs: a candidate waits in the hold buffer until the next one or the run's end. A run compares
// 2 or 4 rows per grid position, one per cycle on each bank's read port while the output does not stall.
// Reset: synchronous active-low; clears control state and configuration registers;
// payload registers and the area store are not reset.
module subsampled_grid_sad_search_top #(
    parameter int unsigned AREA_COLS = 32,
    parameter int unsigned AREA_ROWS = 32,
    parameter int unsigned GRID_STEP = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input word channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cmd,
    input  logic [sgss_pkg::ROW_W-1:0]         i_area_row,
    input  logic [1:0]                         i_column_group,
    input  logic [sgss_pkg::WORD_W-1:0]        i_pixel_word,
    // Result word channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sgss_pkg::SAD_W-1:0]         o_sad_weight,
    output logic [sgss_pkg::OFS_W-1:0]         o_offset_x,
    output logic [sgss_pkg::OFS_W-1:0]         o_offset_y,
    output logic                               o_last_result,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [sgss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sgss_pkg::WORD_W-1:0]        i_cfg_data
);

    // Only the first 32 rows can ever be loaded, so the store is no deeper than that.
    // Each bank holds two 8-pixel groups per row: even groups in one, odd in the other,
    // so any four adjacent columns come from one read of each bank.
    localparam int unsigned ROWS_ST    = (AREA_ROWS < sgss_pkg::LOAD_ROWS) ?
                                         AREA_ROWS : sgss_pkg::LOAD_ROWS;
    localparam int unsigned BANK_DEPTH = ROWS_ST * 2;
    localparam int unsigned AW         = $clog2(BANK_DEPTH);
    localparam logic [6:0]  STEP7      = 7'(GRID_STEP);

    // Configuration registers.
    logic [sgss_pkg::WORD_W-1:0] r_ref_low;
    logic [sgss_pkg::WORD_W-1:0] r_ref_high;
    logic                        r_four_rows;
    logic [sgss_pkg::OFS_W-1:0]  r_width;
    logic [sgss_pkg::OFS_W-1:0]  r_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_low   <= '0;
            r_ref_high  <= '0;
            r_four_rows <= 1'b1;
            r_width     <= 6'd56;
            r_depth     <= 6'd56;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgss_pkg::CFG_REF_LOW:    r_ref_low   <= i_cfg_data;
                sgss_pkg::CFG_REF_HIGH:   r_ref_high  <= i_cfg_data;
                sgss_pkg::CFG_FOUR_ROWS:  r_four_rows <= i_cfg_data[0];
                sgss_pkg::CFG_SRCH_WIDTH: r_width     <= i_cfg_data[5:0];
                sgss_pkg::CFG_SRCH_DEPTH: r_depth     <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Pipeline control state.
    // Issue stage: grid walker that sends one row read per cycle to both banks unless the pipeline is frozen.
    logic                        r_issuing;
    logic [sgss_pkg::OFS_W-1:0]  r_x;
    logic [sgss_pkg::OFS_W-1:0]  r_y;
    logic [1:0]                  r_row;
    // Accumulate stage: RAM data is valid here.
    logic                        r_s1_valid;
    sgss_pkg::t_rd_meta          r_s1_meta;
    logic [sgss_pkg::SAD_W-1:0]  r_acc;
    // Decision stage: one finished SAD per grid position.
    logic                        r_s2_valid;
    logic [sgss_pkg::SAD_W-1:0]  r_s2_sad;
    logic [sgss_pkg::OFS_W-1:0]  r_s2_x;
    logic [sgss_pkg::OFS_W-1:0]  r_s2_y;
    logic                        r_s2_last_pos;
    logic [sgss_pkg::THR_W-1:0]  r_thr;
    logic [sgss_pkg::CNT_W-1:0]  r_cnt;
    // Hold buffer: the newest candidate waits here until we know whether it is the last.
    logic                        r_hold_valid;
    logic                        r_hold_last;
    logic [sgss_pkg::SAD_W-1:0]  r_hold_sad;
    logic [sgss_pkg::OFS_W-1:0]  r_hold_x;
    logic [sgss_pkg::OFS_W-1:0]  r_hold_y;
    // Output register.
    logic                        r_out_valid;
    logic                        r_out_last;
    logic [sgss_pkg::SAD_W-1:0]  r_out_sad;
    logic [sgss_pkg::OFS_W-1:0]  r_out_x;
    logic [sgss_pkg::OFS_W-1:0]  r_out_y;

    // The input side is held off while any part of a run is still in flight. A result
    // still waiting in the output register does not hold off the next word.
    assign o_stall = r_issuing || r_s1_valid || r_s2_valid || r_hold_valid;

    logic in_acc;
    logic run_start;
    assign in_acc    = i_valid && !o_stall;
    assign run_start = in_acc && (i_cmd == sgss_pkg::CMD_RUN);

    // Load path: one whole 8-pixel word goes to one bank entry.
    logic          load_we;
    logic          we_even;
    logic          we_odd;
    logic [AW-1:0] waddr;
    assign load_we = in_acc && (i_cmd == sgss_pkg::CMD_LOAD) &&
                     (32'(i_area_row) < AREA_ROWS);
    assign we_even = load_we && !i_column_group[0];
    assign we_odd  = load_we && i_column_group[0];
    assign waddr   = AW'({i_area_row, i_column_group[1]});

    // Output-side handshake and the stall that backs up into the pipeline.
    logic out_free;
    logic hit;
    logic s2_push;
    logic advance;
    logic [sgss_pkg::THR_W-1:0] quad_sad;

    assign out_free = !r_out_valid || !i_stall;
    assign hit      = ({5'b0, r_s2_sad} <= r_thr);
    assign quad_sad = {3'b0, r_s2_sad, 2'b00};
    assign s2_push  = r_s2_valid && hit && (r_cnt < sgss_pkg::MAX_RESULTS);
    // The whole pipeline freezes when a new candidate would push the held one out
    // but the output register cannot take it.
    assign advance  = !(s2_push && r_hold_valid && !out_free);

    // Issue stage address generation.
    logic [1:0]                 nrows_m1;
    logic [sgss_pkg::ROW_W-1:0] rd_row;
    logic                       rd_row_ok;
    logic [sgss_pkg::ROW_W-1:0] rd_row_addr;
    logic [3:0]                 rd_c0;
    logic [AW-1:0]              raddr_even;
    logic [AW-1:0]              raddr_odd;
    logic [6:0]                 x_next;
    logic [6:0]                 y_next;
    logic                       last_x;
    logic                       last_y;
    logic                       last_row;
    logic                       rd_en;

    assign nrows_m1    = r_four_rows ? 2'd3 : 2'd1;
    assign rd_row      = {1'b0, r_y[5:2]} + {3'b0, r_row};
    assign rd_row_ok   = (32'(rd_row) < AREA_ROWS);
    assign rd_row_addr = rd_row_ok ? rd_row : '0;
    assign rd_c0       = r_x[5:2];
    // Columns c0..c0+3 lie in groups g and g+1 with g = c0/8 being 0 or 1:
    // the odd bank always supplies group 1, the even bank group 0 or 2.
    assign raddr_even  = AW'({rd_row_addr, rd_c0[3]});
    assign raddr_odd   = AW'({rd_row_addr, 1'b0});
    assign x_next      = {1'b0, r_x} + STEP7;
    assign y_next      = {1'b0, r_y} + STEP7;
    assign last_x      = (x_next > {1'b0, r_width});
    assign last_y      = (y_next > {1'b0, r_depth});
    assign last_row    = (r_row == nrows_m1);
    assign rd_en       = advance && r_issuing;

    logic [sgss_pkg::WORD_W-1:0] rdata_even;
    logic [sgss_pkg::WORD_W-1:0] rdata_odd;

    sgss_ram #(
        .WIDTH(sgss_pkg::WORD_W),
        .DEPTH(BANK_DEPTH)
    ) u_bank_even (
        .i_clk  (i_clk),
        .i_we   (we_even),
        .i_waddr(waddr),
        .i_wdata(i_pixel_word),
        .i_re   (rd_en),
        .i_raddr(raddr_even),
        .o_rdata(rdata_even)
    );

    sgss_ram #(
        .WIDTH(sgss_pkg::WORD_W),
        .DEPTH(BANK_DEPTH)
    ) u_bank_odd (
        .i_clk  (i_clk),
        .i_we   (we_odd),
        .i_waddr(waddr),
        .i_wdata(i_pixel_word),
        .i_re   (rd_en),
        .i_raddr(raddr_odd),
        .o_rdata(rdata_odd)
    );

    // Accumulate stage: pick the four area pixels out of the 16-pixel window, mask
    // pixels that fall outside the area, and add this row's absolute differences.
    logic [2*sgss_pkg::WORD_W-1:0] window;
    logic [2*sgss_pkg::WORD_W-1:0] shifted;
    logic [sgss_pkg::WORD_W-1:0]   ref_word;
    logic [31:0]                   ref_row_px;
    logic [sgss_pkg::ROWSAD_W-1:0] row_sad;
    logic [sgss_pkg::SAD_W-1:0]    acc_sum;

    always_comb begin
        logic [sgss_pkg::ROW_W-1:0] col;
        logic [sgss_pkg::PIX_W-1:0] a_px;
        logic [sgss_pkg::PIX_W-1:0] b_px;
        logic [sgss_pkg::PIX_W-1:0] diff;
        window     = r_s1_meta.c0[3] ? {rdata_even, rdata_odd} : {rdata_odd, rdata_even};
        shifted    = window >> {r_s1_meta.c0[2:0], 3'b000};
        ref_word   = r_s1_meta.ref_row[1] ? r_ref_high : r_ref_low;
        ref_row_px = r_s1_meta.ref_row[0] ? ref_word[63:32] : ref_word[31:0];
        row_sad    = '0;
        for (int k = 0; k < sgss_pkg::BLOCK_W; k++) begin
            col  = {1'b0, r_s1_meta.c0} + sgss_pkg::ROW_W'(k);
            a_px = (r_s1_meta.row_ok && (32'(col) < AREA_COLS)) ?
                   shifted[k*sgss_pkg::PIX_W +: sgss_pkg::PIX_W] : '0;
            b_px = ref_row_px[k*sgss_pkg::PIX_W +: sgss_pkg::PIX_W];
            diff = (a_px > b_px) ? (a_px - b_px) : (b_px - a_px);
            row_sad = row_sad + sgss_pkg::ROWSAD_W'(diff);
        end
        acc_sum = ((r_s1_meta.ref_row == 2'd0) ? '0 : r_acc) +
                  sgss_pkg::SAD_W'(row_sad);
    end

    // Walker, accumulate and decision stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing  <= 1'b0;
            r_x        <= '0;
            r_y        <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_thr      <= sgss_pkg::THRESH_START;
            r_cnt      <= '0;
        end else if (run_start) begin
            r_issuing <= 1'b1;
            r_x       <= '0;
            r_y       <= '0;
            r_row     <= '0;
            r_thr     <= sgss_pkg::THRESH_START;
            r_cnt     <= '0;
        end else if (advance) begin
            if (r_issuing) begin
                if (!last_row) begin
                    r_row <= r_row + 2'd1;
                end else begin
                    r_row <= '0;
                    if (!last_x) begin
                        r_x <= x_next[5:0];
                    end else if (!last_y) begin
                        r_x <= '0;
                        r_y <= y_next[5:0];
                    end else begin
                        // Final position issued; the walker keeps the last offsets.
                        r_issuing <= 1'b0;
                    end
                end
            end
            r_s1_valid <= r_issuing;
            r_s2_valid <= r_s1_valid && r_s1_meta.last_row;
            if (r_s2_valid && hit) begin
                if (quad_sad < r_thr) begin
                    r_thr <= quad_sad;
                end
                if (s2_push) begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
        end
    end

    // Payload registers of the pipeline need no reset.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_issuing) begin
                r_s1_meta.x        <= r_x;
                r_s1_meta.y        <= r_y;
                r_s1_meta.c0       <= rd_c0;
                r_s1_meta.row_ok   <= rd_row_ok;
                r_s1_meta.ref_row  <= r_row;
                r_s1_meta.last_row <= last_row;
                r_s1_meta.last_pos <= last_x && last_y;
            end
            if (r_s1_valid) begin
                r_acc <= acc_sum;
                if (r_s1_meta.last_row) begin
                    r_s2_sad      <= acc_sum;
                    r_s2_x        <= r_s1_meta.x;
                    r_s2_y        <= r_s1_meta.y;
                    r_s2_last_pos <= r_s1_meta.last_pos;
                end
            end
        end
    end

    // Hold buffer and output register. A held candidate leaves as a non-final word
    // when a newer one replaces it, or as the final word once the run has ended.
    logic s2_fire;
    assign s2_fire = advance && r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_hold_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_free) begin
                if (s2_fire && s2_push && r_hold_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b0;
                    r_out_sad   <= r_hold_sad;
                    r_out_x     <= r_hold_x;
                    r_out_y     <= r_hold_y;
                end else if (r_hold_valid && r_hold_last) begin
                    r_out_valid  <= 1'b1;
                    r_out_last   <= 1'b1;
                    r_out_sad    <= r_hold_sad;
                    r_out_x      <= r_hold_x;
                    r_out_y      <= r_hold_y;
                    r_hold_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
            if (s2_fire) begin
                if (s2_push) begin
                    r_hold_valid <= 1'b1;
                    r_hold_last  <= r_s2_last_pos;
                    r_hold_sad   <= r_s2_sad;
                    r_hold_x     <= r_s2_x;
                    r_hold_y     <= r_s2_y;
                end else if (r_s2_last_pos) begin
                    r_hold_last <= 1'b1;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sad_weight  = r_out_sad;
    assign o_offset_x    = r_out_x;
    assign o_offset_y    = r_out_y;
    assign o_last_result = r_out_last;

    // A candidate marked final means the walker and both pipeline stages have drained.
    a_final_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_valid && r_hold_last) |-> (!r_issuing && !r_s1_valid && !r_s2_valid))
        else $error("final candidate held while the run is still in flight");

    // No more candidates than the per-run limit are ever counted.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sgss_pkg::MAX_RESULTS)
        else $error("candidate count above the per-run limit");

    // Within a run the threshold never rises.
    a_thr_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !run_start |=> (r_thr <= $past(r_thr)))
        else $error("threshold rose without a new run");

endmodule

// ===== rtl/core/sgss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sgss_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
